FILE: hw/rtl/pws_pkg.sv
package pws_pkg;

  localparam int CHIPS        = 8;
  localparam int NATIVE_WIDTH = 2560;

  // Native width as a column value
  localparam logic [11:0] NW = 12'(NATIVE_WIDTH);

  // Column range of each driver chip, first and last column
  localparam logic [11:0] CHIP_LO [0:7] = '{
    12'd0, 12'd400, 12'd800, 12'd1200, 12'd1280, 12'd1680, 12'd2080, 12'd2480
  };
  localparam logic [11:0] CHIP_HI [0:7] = '{
    12'd399, 12'd799, 12'd1199, 12'd1279, 12'd1679, 12'd2079, 12'd2479, 12'd2559
  };

  // Window queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // Configuration register indexes
  localparam logic [0:0] REG_ROTATION   = 1'b0;
  localparam logic [0:0] REG_PANEL_ROWS = 1'b1;

  localparam logic [10:0] PANEL_ROWS_RST = 11'd1440;

  typedef enum logic [1:0] {
    ROT_180 = 2'd0,
    ROT_QA  = 2'd1,
    ROT_ID  = 2'd2,
    ROT_QB  = 2'd3
  } rot_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  typedef struct packed {
    rot_t        rotation;
    logic [10:0] panel_rows;
  } cfg_t;

  // Native window after alignment
  typedef struct packed {
    logic [11:0] cs;
    logic [11:0] ce;
    logic [10:0] rs;
    logic [10:0] re;
  } win_t;

  typedef struct packed {
    logic [2:0]  chip_index;
    logic        in_window;
    logic [9:0]  h_start;
    logic [9:0]  h_end;
    logic [9:0]  v_start;
    logic [9:0]  v_end;
    logic [10:0] first_row;
    logic [11:0] row_count;
    logic [7:0]  byte_col_start;
    logic [7:0]  bytes_per_row;
    logic        last_chip;
  } res_t;

endpackage

FILE: hw/rtl/pws_front.sv
module pws_front
  import pws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [12:0] in_x,
  input  logic signed [12:0] in_y,
  input  logic signed [12:0] in_w,
  input  logic signed [12:0] in_h,
  output logic               push,
  output win_t               push_win,
  input  logic               q_full
);

  logic               en;
  logic               s1_valid;
  logic [11:0]        s1_x, s1_y;
  logic signed [13:0] s1_w, s1_h;
  logic [11:0]        s1_x_next, s1_y_next;
  logic signed [13:0] s1_w_next, s1_h_next;
  logic signed [13:0] wx, hy;

  logic               s2_valid;
  logic [11:0]        s2_x, s2_y, s2_w, s2_h;

  logic               upright;
  logic [11:0]        nh, uw, uh;
  logic signed [14:0] xw, yh, cap_w, cap_h, w2, h2;
  logic               nonempty;

  logic [11:0]        cs, ce, rs, re;
  logic [11:0]        ce_or, re_ext;
  logic               even;

  // Single enable: the whole front holds while the queue is full and stage 2 holds a window
  assign en       = !s2_valid || !q_full;
  assign in_ready = en;
  assign push     = s2_valid && !q_full;

  // Near-edge clip: drop the part left of or above the screen
  assign wx = {in_w[12], in_w} + {in_x[12], in_x};
  assign hy = {in_h[12], in_h} + {in_y[12], in_y};
  assign s1_w_next = in_x[12] ? wx : {in_w[12], in_w};
  assign s1_h_next = in_y[12] ? hy : {in_h[12], in_h};
  assign s1_x_next = in_x[12] ? 12'd0 : in_x[11:0];
  assign s1_y_next = in_y[12] ? 12'd0 : in_y[11:0];

  // Far-edge clip against the rotated screen size
  assign upright = !cfg.rotation[0];
  assign nh      = {1'b0, cfg.panel_rows};
  assign uw      = upright ? NW : nh;
  assign uh      = upright ? nh : NW;

  assign xw    = $signed({3'b0, s1_x}) + {s1_w[13], s1_w};
  assign yh    = $signed({3'b0, s1_y}) + {s1_h[13], s1_h};
  assign cap_w = $signed({3'b0, uw}) - $signed({3'b0, s1_x});
  assign cap_h = $signed({3'b0, uh}) - $signed({3'b0, s1_y});
  assign w2    = (xw > $signed({3'b0, uw})) ? cap_w : {s1_w[13], s1_w};
  assign h2    = (yh > $signed({3'b0, uh})) ? cap_h : {s1_h[13], s1_h};
  assign nonempty = !w2[14] && (|w2) && !h2[14] && (|h2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid && nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= s1_x_next;
      s1_y <= s1_y_next;
      s1_w <= s1_w_next;
      s1_h <= s1_h_next;
      s2_x <= s1_x;
      s2_y <= s1_y;
      s2_w <= w2[11:0];
      s2_h <= h2[11:0];
    end
  end

  // Map to native columns and rows
  always_comb begin
    unique case (cfg.rotation)
      ROT_180: begin
        cs = NW - s2_x - s2_w;
        ce = NW - 12'd1 - s2_x;
        rs = nh - s2_y - s2_h;
        re = nh - 12'd1 - s2_y;
      end
      ROT_ID: begin
        cs = s2_x;
        ce = s2_x + s2_w - 12'd1;
        rs = s2_y;
        re = s2_y + s2_h - 12'd1;
      end
      ROT_QB: begin
        cs = NW - s2_y - s2_h;
        ce = NW - 12'd1 - s2_y;
        rs = s2_x;
        re = s2_x + s2_w - 12'd1;
      end
      default: begin
        cs = s2_y;
        ce = s2_y + s2_h - 12'd1;
        rs = nh - s2_x - s2_w;
        re = nh - 12'd1 - s2_x;
      end
    endcase
  end

  // Widen columns to 8, make the row count even, clamp to the panel
  assign ce_or  = ce | 12'd7;
  assign even   = (re[0] == rs[0]);
  assign re_ext = re + {11'b0, even};

  always_comb begin
    push_win.cs = {cs[11:3], 3'b000};
    push_win.ce = (ce_or >= NW) ? (NW - 12'd1) : ce_or;
    push_win.rs = rs[10:0];
    push_win.re = (re_ext >= nh) ? cfg.panel_rows - 11'd1 : re_ext[10:0];
  end

endmodule

FILE: hw/rtl/pws_fifo.sv
module pws_fifo
  import pws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  win_t push_win,
  output logic full,
  input  logic pop,
  output logic valid,
  output win_t head
);

  win_t            slots [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] count;

  assign full  = (count == Q_CW'(Q_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pws_back.sv
module pws_back
  import pws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  win_t q_head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  bk_state_t   state, state_next;
  win_t        cur;
  logic [2:0]  idx;
  logic        adv, emit, last;
  logic [11:0] xs, xe, a, b, lxp;
  logic        hit;
  logic [11:0] re1;
  res_t        res;

  assign adv  = !out_valid || out_ready;
  assign last = (idx == 3'(CHIPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_RUN;
      BK_RUN:  if (adv && last && !q_valid) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    pop  = 1'b0;
    unique case (state)
      BK_IDLE: pop = q_valid;
      BK_RUN: begin
        emit = adv;
        pop  = adv && last && q_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        idx <= '0;
      end else if (emit) begin
        idx <= idx + 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (emit) begin
      out_res <= res;
    end
  end

  // Per-chip window
  assign xs  = CHIP_LO[idx];
  assign xe  = CHIP_HI[idx];
  assign hit = (cur.cs <= xe) && (cur.ce >= xs);
  assign a   = (cur.cs > xs) ? (cur.cs - xs) : 12'd0;
  assign b   = (cur.ce < xe) ? (cur.ce - xs) : (xe - xs);
  assign lxp = b - a + 12'd1;
  assign re1 = {1'b0, cur.re} + 12'd1;

  always_comb begin
    res.chip_index = idx;
    res.in_window  = hit;
    res.last_chip  = last;
    if (hit) begin
      res.h_start        = 10'({a, 1'b0});
      res.h_end          = 10'({b, 1'b1});
      res.v_start        = 10'(cur.rs >> 1);
      res.v_end          = 10'(re1 >> 1) - 10'd1;
      res.first_row      = cur.rs;
      res.row_count      = {1'b0, cur.re} - {1'b0, cur.rs} + 12'd1;
      res.byte_col_start = 8'(a >> 1);
      res.bytes_per_row  = 8'(lxp >> 1);
    end else begin
      // Dummy window: 8 columns by 2 rows at the origin
      res.h_start        = 10'd0;
      res.h_end          = 10'd15;
      res.v_start        = 10'd0;
      res.v_end          = 10'd0;
      res.first_row      = 11'd0;
      res.row_count      = 12'd2;
      res.byte_col_start = 8'd0;
      res.bytes_per_row  = 8'd4;
    end
  end

endmodule

FILE: hw/rtl/partial_window_chip_splitter.sv
// Path: an input beat is registered in front stages s1 and s2, queued, popped into
//   the back end, and each chip's result goes into the output register; the beats
//   for the other chips follow one per cycle while the receiver accepts them. The
//   back end produces one result beat per driver chip from a single compute unit.
// Reset (rst, synchronous): rotation 0, panel_rows 1440, pipeline and queue empty.
module partial_window_chip_splitter
  import pws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  // Window input. s_tdata: win_x[12:0], win_y[25:13], win_w[38:26], win_h[51:39]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,

  // Result output. m_tdata: chip_index[2:0], h_start[12:3], h_end[22:13],
  //   v_start[32:23], v_end[42:33], first_row[53:43], row_count[65:54],
  //   byte_col_start[73:66], bytes_per_row[81:74]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,
  output logic [0:0]  m_tuser,   // in_window[0]
  output logic        m_tlast,   // last_chip

  // Configuration writes: index 0 rotation, index 1 panel_rows
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  cfg_t cfg;
  logic push, q_full, q_valid, pop;
  win_t push_win, q_head;
  res_t res;

  // Configuration registers; take a write on any beat. The host must write them only
  // while the block is idle; the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation   <= ROT_180;
      cfg.panel_rows <= PANEL_ROWS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROTATION:   cfg.rotation   <= rot_t'(cfg_data[1:0]);
        REG_PANEL_ROWS: cfg.panel_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: clip, rotate, align; empty windows are dropped here
  pws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_x     (s_tdata[12:0]),
    .in_y     (s_tdata[25:13]),
    .in_w     (s_tdata[38:26]),
    .in_h     (s_tdata[51:39]),
    .push     (push),
    .push_win (push_win),
    .q_full   (q_full)
  );

  // Short queue of native windows so the front keeps taking beats while
  // the back end walks the chips
  pws_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_win (push_win),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back end: one chip per cycle into the output register while the receiver accepts
  pws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {6'b0, res.bytes_per_row, res.byte_col_start, res.row_count,
                    res.first_row, res.v_end, res.v_start, res.h_end, res.h_start,
                    res.chip_index};
  assign m_tuser = res.in_window;
  assign m_tlast = res.last_chip;

  // The final beat of a window always belongs to the last chip
  a_last_chip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[2:0] == 3'(CHIPS - 1))
    else $error("last beat not on the final chip");

  // Dummy windows carry the fixed 8 by 2 geometry
  a_dummy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[65:54] == 12'd2 && m_tdata[81:74] == 8'd4)
    else $error("dummy window geometry wrong");

  // A chip inside the window ends after where it starts
  a_h_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[22:13] > m_tdata[12:3])
    else $error("h_end not above h_start");

endmodule

FILE: dv/pws_checker.sv
module pws_checker
  import pws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,    // win_x, win_y, win_w, win_h (13 bits each)
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,    // chip_index, h_start, h_end, v_start, v_end,
                                  // first_row, row_count, byte_col_start, bytes_per_row
  input  logic [0:0]  m_tuser,    // in_window
  input  logic        m_tlast,    // last_chip
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  localparam int          COL_EDGE [0:8] = '{0, 400, 800, 1200, 1280, 1680, 2080, 2480, 2560};
  localparam logic [10:0] ROWS_AT_RESET  = 11'd1440;

  rot_t        cur_rot  = ROT_180;
  logic [10:0] cur_rows = ROWS_AT_RESET;
  res_t        chip_regs_due [$];
  int          bad = 0;
  int          got = 0;

  // Clip one window, map it to native space and queue the register set of every chip.
  function automatic void split_window(input logic [55:0] beat);
    int   x, y, w, h, nw, nh, uw, uh, cs, ce, rs, re, lo, hi, lxs, lxp, lys, lyl;
    bit   upright, hit;
    res_t r;
    x  = $signed(beat[12:0]);
    y  = $signed(beat[25:13]);
    w  = $signed(beat[38:26]);
    h  = $signed(beat[51:39]);
    nw = NATIVE_WIDTH;
    nh = int'(cur_rows);
    upright = (cur_rot == ROT_180) || (cur_rot == ROT_ID);
    uw = upright ? nw : nh;
    uh = upright ? nh : nw;

    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > uw) w = uw - x;
    if (y + h > uh) h = uh - y;
    if (w <= 0 || h <= 0) return;

    case (cur_rot)
      ROT_180: begin
        cs = nw - x - w; ce = nw - 1 - x;
        rs = nh - y - h; re = nh - 1 - y;
      end
      ROT_ID: begin
        cs = x; ce = x + w - 1;
        rs = y; re = y + h - 1;
      end
      ROT_QB: begin
        cs = nw - y - h; ce = nw - 1 - y;
        rs = x;          re = x + w - 1;
      end
      default: begin
        cs = y;          ce = y + h - 1;
        rs = nh - x - w; re = nh - 1 - x;
      end
    endcase

    // widen columns to whole groups of 8, even out the row count, clamp to the panel
    if (cs < 0) cs = 0;
    cs = (cs / 8) * 8;
    ce = ((ce + 8) / 8) * 8 - 1;
    if (ce >= nw) ce = nw - 1;
    if (rs < 0) rs = 0;
    if (((re - rs + 1) & 1) != 0) re++;
    if (re >= nh) re = nh - 1;

    for (int c = 0; c < CHIPS; c++) begin
      lo  = COL_EDGE[c];
      hi  = COL_EDGE[c + 1] - 1;
      hit = (cs <= hi) && (ce >= lo);
      if (hit) begin
        lxs = (cs > lo) ? cs - lo : 0;
        lxp = ((ce < hi) ? ce - lo : hi - lo) - lxs + 1;
        lys = rs;
        lyl = re - rs + 1;
      end else begin
        lxs = 0; lxp = 8; lys = 0; lyl = 2;
      end
      r.chip_index     = 3'(c);
      r.in_window      = hit;
      r.h_start        = 10'(lxs * 2);
      r.h_end          = 10'((lxs + lxp) * 2 - 1);
      r.v_start        = 10'(lys / 2);
      r.v_end          = 10'((lys + lyl) / 2 - 1);
      r.first_row      = 11'(lys);
      r.row_count      = 12'(lyl);
      r.byte_col_start = 8'(lxs / 2);
      r.bytes_per_row  = 8'(lxp / 2);
      r.last_chip      = (c == CHIPS - 1);
      chip_regs_due.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    res_t act;
    res_t want;
    if (rst) begin
      cur_rot  = ROT_180;
      cur_rows = ROWS_AT_RESET;
      chip_regs_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        act.chip_index     = m_tdata[2:0];
        act.in_window      = m_tuser[0];
        act.h_start        = m_tdata[12:3];
        act.h_end          = m_tdata[22:13];
        act.v_start        = m_tdata[32:23];
        act.v_end          = m_tdata[42:33];
        act.first_row      = m_tdata[53:43];
        act.row_count      = m_tdata[65:54];
        act.byte_col_start = m_tdata[73:66];
        act.bytes_per_row  = m_tdata[81:74];
        act.last_chip      = m_tlast;
        got++;
        if (chip_regs_due.size() == 0) begin
          bad++;
          if (bad <= 10) $display("%0t: result beat with none due: %p", $realtime, act);
        end else begin
          want = chip_regs_due.pop_front();
          if (act !== want) begin
            bad++;
            if (bad <= 10) begin
              $display("%0t: chip result mismatch", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", act);
            end
          end
        end
      end
      if (s_tvalid && s_tready) split_window(s_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROTATION) cur_rot = rot_t'(cfg_data[1:0]);
        else cur_rows = cfg_data;
      end
    end
    mismatches <= bad;
    pending    <= chip_regs_due.size();
    checked    <= got;
  end

endmodule

FILE: dv/tb.sv
module tb;
  import pws_pkg::*;

  // Register settings per phase; phase 0 runs on the reset values and writes nothing.
  localparam int   N_PHASES = 14;
  localparam rot_t PHASE_ROT [0:N_PHASES-1] = '{
    ROT_180, ROT_ID, ROT_QA, ROT_QB, ROT_180, ROT_QA, ROT_ID,
    ROT_QB, ROT_180, ROT_ID, ROT_QA, ROT_QB, ROT_180, ROT_ID
  };
  localparam int PHASE_ROWS  [0:N_PHASES-1] = '{
    1440, 1440, 1440, 1440, 2046, 2, 1023, 2047, 1, 0, 2046, 3, 1440, 2
  };
  localparam int PHASE_ITEMS [0:N_PHASES-1] = '{
    40, 60, 60, 60, 40, 25, 40, 40, 15, 10, 40, 25, 40, 25
  };

  localparam int HOLD_PHASE   = 2;       // phase in which the output backs up
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    RX_FREE,      // never stall
    RX_HALF,      // coin flip each cycle
    RX_RARE,      // stall one cycle in ten
    RX_THIRD      // accept only on a steady sparse pattern
  } rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;    // win_x[12:0], win_y[25:13], win_w[38:26], win_h[51:39]
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;    // chip_index, h_start, h_end, v_start, v_end,
                           // first_row, row_count, byte_col_start, bytes_per_row
  logic [0:0]  m_tuser;    // in_window[0]
  logic        m_tlast;    // last_chip
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int sent        = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  bit want_hold   = 1'b0;

  partial_window_chip_splitter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pws_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pack four user-space coordinates into one window beat, upper bits zero.
  function automatic logic [55:0] pack_win(input int x, input int y, input int w, input int h);
    return {4'b0, h[12:0], w[12:0], y[12:0], x[12:0]};
  endfunction

  // Draw a window: mostly proper rectangles on the user screen, some tiny ones near
  // the edges, the rest raw 13-bit noise (that part also flips every input bit).
  function automatic logic [55:0] pick_window(input int uw, input int uh);
    int x, y, w, h, sel;
    sel = $urandom_range(0, 99);
    if (sel < 60 && uw > 0 && uh > 0) begin
      x = $urandom_range(0, uw - 1);
      w = $urandom_range(1, uw - x);
      y = $urandom_range(0, uh - 1);
      h = $urandom_range(1, uh - y);
      // hang over the top-left edge now and then to exercise clipping
      if ($urandom_range(0, 3) == 0) begin
        x -= $urandom_range(0, 40);
        w += $urandom_range(0, 80);
      end
      if ($urandom_range(0, 3) == 0) begin
        y -= $urandom_range(0, 40);
        h += $urandom_range(0, 80);
      end
    end else if (sel < 80 && uw > 0 && uh > 0) begin
      x = $urandom_range(0, uw + 7) - 4;
      w = $urandom_range(0, 10) - 2;
      y = $urandom_range(0, uh + 7) - 4;
      h = $urandom_range(0, 10) - 2;
    end else begin
      x = $urandom_range(0, 8191) - 4096;
      y = $urandom_range(0, 8191) - 4096;
      w = $urandom_range(0, 8191) - 4096;
      h = $urandom_range(0, 8191) - 4096;
    end
    return pack_win(x, y, w, h);
  endfunction

  // Offer one window and hold it until taken. Drop valid at the end of a burst or
  // phase, then idle a random gap before the next burst.
  task automatic push_window(input logic [55:0] beat, input bit phase_end);
    int gap;
    s_tdata  <= beat;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 || phase_end) begin
      s_tvalid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Write one register; keep valid up when another write follows right away.
  task automatic write_reg(input logic [0:0] idx, input logic [10:0] val, input bit more);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Wait for every due result, then let any empty windows still in the front pipeline pass through.
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: pick a new random stall pattern whenever the current one runs out; once, hold off for a long
  // stretch so that the window queue fills and the input stalls.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       hold_used;
    m_tready  = 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (want_hold && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE: m_tready <= 1'b1;
          RX_HALF: m_tready <= ($urandom_range(0, 1) == 0);
          RX_RARE: m_tready <= ($urandom_range(0, 9) != 0);
          default: m_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL partial_window_chip_splitter");
    $finish;
  end

  initial begin : stimulus
    int uw;
    int uh;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst        = 1'b1;
    burst_left = $urandom_range(1, 24);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed windows on the reset setting (180 degrees, 1440 rows).
    push_window(pack_win(0, 0, 2560, 1440), 0);            // whole screen, every chip hit
    push_window(pack_win(-4096, -4096, 4095, 4095), 0);    // most negative corner, largest size
    push_window(pack_win(4095, 4095, 4095, 4095), 0);      // starts off screen: empty
    push_window(pack_win(0, 0, 0, 10), 0);                 // zero width: empty
    push_window(pack_win(0, 0, 10, -4096), 0);             // most negative height: empty
    push_window(pack_win(-1, -1, -1, -1), 0);              // all ones: empty
    push_window(pack_win(0, 0, 1, 1), 0);                  // single pixel, first corner
    push_window(pack_win(2559, 1439, 1, 1), 0);            // single pixel, far corner
    push_window(pack_win(410, 10, 8, 2), 0);               // inside one chip
    push_window(pack_win(1270, 100, 20, 3), 0);            // across a chip edge, odd height
    push_window(pack_win(3, 5, 5, 7), 0);                  // unaligned columns
    push_window(pack_win(-100, -50, 200, 100), 0);         // clipped at top left
    push_window(pack_win(2000, 1400, 1000, 1000), 0);      // clipped at bottom right
    push_window(pack_win(1200, 0, 80, 1440), 0);           // 80 columns, maps to the start of chip 4 at 180 degrees

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        settle();
        write_reg(REG_ROTATION, 11'(PHASE_ROT[p]), 1'b1);
        write_reg(REG_PANEL_ROWS, 11'(PHASE_ROWS[p]), 1'b0);
      end
      uw = (PHASE_ROT[p] == ROT_180 || PHASE_ROT[p] == ROT_ID) ? NATIVE_WIDTH : PHASE_ROWS[p];
      uh = (PHASE_ROT[p] == ROT_180 || PHASE_ROT[p] == ROT_ID) ? PHASE_ROWS[p] : NATIVE_WIDTH;
      // open each setting with the largest window, then random ones
      push_window(pack_win(0, 0, 4095, 4095), 1'b0);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (p == HOLD_PHASE && n == 10) want_hold = 1'b1;
        push_window(pick_window(uw, uh), n == PHASE_ITEMS[p] - 1);
      end
    end

    settle();
    $display("windows sent: %0d across %0d register settings; chip results checked: %0d",
             sent, N_PHASES, checked);
    $display("output held off once for %0d cycles; run took %0d cycles",
             HOLD_CYCLES, cycle_count);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS partial_window_chip_splitter");
    end else begin
      $display("FAIL partial_window_chip_splitter");
    end
    $finish;
  end

endmodule
